// ===== sv/ple_pkg.sv =====
// ple_pkg: shared types and constants of the positional list engine.
// Holds request/response payload structs, status codes and the cell control bundle.
// Used by ple_cell and positional_list_engine.
package ple_pkg;

    localparam int DATA_W       = 8;
    localparam int POS_W        = 5;
    localparam int LEN_W        = 5;
    localparam int DEF_CAPACITY = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [DATA_W-1:0] ERR_BYTE = 8'hFF;

    typedef struct packed {
        logic              req_type;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] removed_value;
        logic [1:0]        status;
        logic [LEN_W-1:0]  length;
    } t_rsp;

    // Broadcast to every cell of the chain in the cycle a beat commits.
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } t_cell_ctrl;

endpackage

// ===== sv/positional_list_engine.sv =====
// positional_list_engine: ordered byte list with insert/delete at a 1-based position.
// Top level; builds a chain of ple_cell slots plus count and status logic.
// Depends on ple_pkg and ple_cell.
//
//  channel | ports                              | beat carries
//  --------+------------------------------------+----------------------------------
//  request | i_in_valid / o_in_ready / i_in_req | req_type, position, item_value
//  result  | o_out_valid / i_out_ready / o_out_rsp | removed_value, status, length
//
// The cells compare their index with the position and shift at the accept edge, and the result
// is loaded into the output register at that same edge.
// One request per cycle is sustained while the result side is ready; the single output register sets that figure.
// Reset (i_rst_n low at a clock edge) empties the list and drops any pending result.
// A stalled result holds the output register; the request side then stalls too.

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ple_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ple_pkg::t_rsp o_out_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    // compare width: holds count+1 and any position without overflow
    localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
    localparam int DW    = ple_pkg::DATA_W;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    ple_pkg::t_rsp       r_out_rsp;
    ple_pkg::t_rsp       n_out_rsp;
    logic                accept;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    len_ext;
    logic                ins_ok;
    logic                del_ok;
    ple_pkg::t_cell_ctrl ctrl;

    logic [DW-1:0] cell_data [CAPACITY];
    logic [DW-1:0] rd_chain  [CAPACITY+1];

    // take a new beat whenever the output register is free or drains this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign cnt_ext = CMP_W'(r_count);
    assign pos_ext = CMP_W'(i_in_req.position);

    always_comb begin
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        n_count  = r_count;
        n_out_rsp.removed_value = '0;
        n_out_rsp.status        = ple_pkg::ST_OK;
        if (i_in_req.req_type == ple_pkg::REQ_INSERT) begin
            // bad position is checked before full
            if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                n_out_rsp.status = ple_pkg::ST_BADPOS;
            end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
                n_out_rsp.status = ple_pkg::ST_FULL;
            end else begin
                ins_ok  = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            n_out_rsp.removed_value = ple_pkg::ERR_BYTE;
            if (cnt_ext == '0) begin
                n_out_rsp.status = ple_pkg::ST_EMPTY;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                n_out_rsp.status = ple_pkg::ST_BADPOS;
            end else begin
                del_ok  = 1'b1;
                n_count = r_count - CNT_W'(1);
                n_out_rsp.removed_value = rd_chain[0];
            end
        end
        len_ext = CMP_W'(n_count);
        n_out_rsp.length = len_ext[ple_pkg::LEN_W-1:0];
    end

    // broadcast to the cells; they only move on a committed, valid request
    assign ctrl.ins_en = accept && ins_ok;
    assign ctrl.del_en = accept && del_ok;
    assign ctrl.pos    = i_in_req.position;
    assign ctrl.val    = i_in_req.item_value;

    // read chain runs from the tail toward the head; the tail end feeds zero
    assign rd_chain[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DW-1:0] left_d;
        logic [DW-1:0] right_d;
        if (g == 0) begin : g_head
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        ple_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_left_data  (left_d),
            .i_right_data (right_d),
            .i_rd_chain   (rd_chain[g+1]),
            .o_data       (cell_data[g]),
            .o_rd_chain   (rd_chain[g])
        );
    end

    // count and result valid: control state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

// ===== sv/ple_cell.sv =====
// ple_cell: one slot of the list chain, holding a byte and shifting with its neighbors.
// Also forwards the selected byte along a read chain toward the head.
// Depends on ple_pkg.
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  ple_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ple_pkg::DATA_W-1:0] i_left_data,
    input  logic [ple_pkg::DATA_W-1:0] i_right_data,
    input  logic [ple_pkg::DATA_W-1:0] i_rd_chain,
    output logic [ple_pkg::DATA_W-1:0] o_data,
    output logic [ple_pkg::DATA_W-1:0] o_rd_chain
);

    logic [ple_pkg::DATA_W-1:0] r_data;
    logic [ple_pkg::DATA_W-1:0] n_data;
    logic                       hit;   // this cell sits at position
    logic                       after; // this cell lies past position

    assign hit   = (IDX + 1 == int'(i_ctrl.pos));
    assign after = (IDX + 1 >  int'(i_ctrl.pos));

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins_en) begin
            if (hit) begin
                n_data = i_ctrl.val;
            end else if (after) begin
                n_data = i_left_data;
            end
        end else if (i_ctrl.del_en) begin
            // close the gap: take the neighbor toward the tail
            if (hit || after) begin
                n_data = i_right_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_rd_chain = (hit ? r_data : '0) | i_rd_chain;

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for positional_list_engine.
// Needs ple_pkg and the engine RTL; drives request beats from a queue, predicts
// every result with its own list model and checks each result beat against it.
module tb_top;

    localparam int LIST_CAP    = ple_pkg::DEF_CAPACITY;
    localparam int RANDOM_REQS = 1950;
    // Worst case per beat is roughly the longest send gap plus the longest result
    // stall; take that several times over for the whole run.
    localparam int CYCLE_LIMIT = 500000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Request side: valid and payload driven here, ready from the engine.
    logic          req_valid = 1'b0;
    ple_pkg::t_req req_beat  = '0;
    logic          req_ready;

    // Result side: ready driven here, valid and payload from the engine.
    logic          rsp_valid;
    ple_pkg::t_rsp rsp_beat;
    logic          rsp_ready = 1'b0;

    positional_list_engine #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_req    (req_beat),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_rsp   (rsp_beat)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    ple_pkg::t_req req_pending [$];       // request beats not yet put on the bus
    ple_pkg::t_rsp rsp_expected [$];      // results predicted but not yet seen
    int   fail_count   = 0;
    int   sent_count   = 0;
    int   seen_count   = 0;
    int   status_hits [4];
    int   peak_len     = 0;
    int   cycle_count  = 0;

    // List shadow used by the predictor: contents and current length.
    logic [ple_pkg::DATA_W-1:0] list_bytes [LIST_CAP];
    int                         list_len = 0;

    // Length shadow used only while building stimulus, so that positions can
    // be aimed at the valid range of the list as it will be at that point.
    int gen_len = 0;

    // ------------------------------------------------------------------
    // Predictor: apply one request to the list shadow, return its result.
    // ------------------------------------------------------------------
    function automatic ple_pkg::t_rsp list_apply(ple_pkg::t_req rq);
        ple_pkg::t_rsp r;
        int   p;
        int   k;
        p               = int'(rq.position);
        r.removed_value = '0;
        r.status        = ple_pkg::ST_OK;
        if (rq.req_type == ple_pkg::REQ_INSERT) begin
            // Position is judged first, capacity only after that.
            if (p < 1 || p > list_len + 1) begin
                r.status = ple_pkg::ST_BADPOS;
            end else if (list_len >= LIST_CAP) begin
                r.status = ple_pkg::ST_FULL;
            end else begin
                // Move the tail one place back, then drop the byte in.
                for (k = list_len; k > p - 1; k--)
                    list_bytes[k] = list_bytes[k-1];
                list_bytes[p-1] = rq.item_value;
                list_len++;
            end
        end else begin
            r.removed_value = ple_pkg::ERR_BYTE;
            // An empty list wins over any position check.
            if (list_len == 0) begin
                r.status = ple_pkg::ST_EMPTY;
            end else if (p < 1 || p > list_len) begin
                r.status = ple_pkg::ST_BADPOS;
            end else begin
                r.removed_value = list_bytes[p-1];
                for (k = p - 1; k + 1 < list_len; k++)
                    list_bytes[k] = list_bytes[k+1];
                list_len--;
            end
        end
        r.length = list_len[ple_pkg::LEN_W-1:0];
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long. A calm side never idles.
    function automatic int pick_idle(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    // Queue one request and advance the stimulus length shadow.
    task automatic queue_req(logic kind, int pos, int val);
        ple_pkg::t_req rq;
        rq.req_type   = kind;
        rq.position   = pos[ple_pkg::POS_W-1:0];
        rq.item_value = val[ple_pkg::DATA_W-1:0];
        req_pending.push_back(rq);
        if (kind == ple_pkg::REQ_INSERT) begin
            if (pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_CAP)
                gen_len++;
        end else begin
            if (gen_len > 0 && pos >= 1 && pos <= gen_len)
                gen_len--;
        end
    endtask

    // Byte with a bias toward the all-zeros and all-ones corners.
    function automatic int pick_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        else if (r == 1)
            return 255;
        else
            return $urandom_range(0, 255);
    endfunction

    task automatic queue_good_insert();
        queue_req(ple_pkg::REQ_INSERT, $urandom_range(1, gen_len + 1), pick_byte());
    endtask

    task automatic queue_good_delete();
        queue_req(ple_pkg::REQ_DELETE, $urandom_range(1, gen_len), pick_byte());
    endtask

    // Either request type and any position from 0 to 17, valid or not.
    task automatic queue_noise();
        queue_req(1'($urandom_range(0, 1)), $urandom_range(0, 17), pick_byte());
    endtask

    // ------------------------------------------------------------------
    // Driver: present request beats, predict each one as it is accepted.
    // ------------------------------------------------------------------
    int drv_gap  = 0;
    bit drv_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (req_valid && req_ready) begin
                rsp_expected.push_back(list_apply(req_beat));
                status_hits[rsp_expected[$].status]++;
                if (list_len > peak_len)
                    peak_len = list_len;
                sent_count++;
            end
            // Advance only when the bus is free: nothing up, or taken this edge.
            if (!req_valid || req_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    req_valid <= 1'b0;
                end else if (req_pending.size() != 0) begin
                    req_beat  <= req_pending.pop_front();
                    req_valid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        drv_calm = !drv_calm;
                    drv_gap = pick_idle(drv_calm);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, check every result beat against the oldest
    // prediction.
    // ------------------------------------------------------------------
    int            mon_stall = 0;
    bit            mon_calm  = 1'b0;
    ple_pkg::t_rsp want_rsp;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
            mon_stall = 0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                seen_count++;
                if (rsp_expected.size() == 0) begin
                    $error("result beat with nothing pending: %s %0d status %0d length %0d",
                           "removed_value", rsp_beat.removed_value, rsp_beat.status,
                           rsp_beat.length);
                    fail_count++;
                end else begin
                    want_rsp = rsp_expected.pop_front();
                    if (rsp_beat.removed_value !== want_rsp.removed_value) begin
                        $error("removed_value: expected %0d, actual %0d",
                               want_rsp.removed_value, rsp_beat.removed_value);
                        fail_count++;
                    end
                    if (rsp_beat.status !== want_rsp.status) begin
                        $error("status: expected %0d, actual %0d",
                               want_rsp.status, rsp_beat.status);
                        fail_count++;
                    end
                    if (rsp_beat.length !== want_rsp.length) begin
                        $error("length: expected %0d, actual %0d",
                               want_rsp.length, rsp_beat.length);
                        fail_count++;
                    end
                end
            end
            // Hold ready low for the stall, then give one ready cycle and pick again.
            if (mon_stall > 0) begin
                mon_stall--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    mon_calm = !mon_calm;
                mon_stall = pick_idle(mon_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rsp_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    int mode;
    int run_len;
    int n;

    initial begin
        // Directed part: the empty and bad-position error paths and the head, middle and tail cases.
        queue_req(ple_pkg::REQ_DELETE, 1, 'h12);    // delete from empty list
        queue_req(ple_pkg::REQ_DELETE, 0, 'hFF);    // empty wins even with position 0
        queue_req(ple_pkg::REQ_INSERT, 0, 'h33);    // insert at position 0
        queue_req(ple_pkg::REQ_INSERT, 2, 'h44);    // insert past length+1
        queue_req(ple_pkg::REQ_INSERT, 17, 'h55);   // position 17, still bad
        queue_req(ple_pkg::REQ_INSERT, 1, 'h00);    // first byte
        queue_req(ple_pkg::REQ_INSERT, 2, 'hFF);    // tail insert
        queue_req(ple_pkg::REQ_INSERT, 1, 'hA5);    // head insert
        queue_req(ple_pkg::REQ_INSERT, 2, 'h5A);    // middle insert
        queue_req(ple_pkg::REQ_DELETE, 0, 'h00);    // delete at position 0
        queue_req(ple_pkg::REQ_DELETE, 5, 'h00);    // delete past length
        queue_req(ple_pkg::REQ_DELETE, 4, 'h00);    // tail delete
        queue_req(ple_pkg::REQ_DELETE, 2, 'h00);    // middle delete
        queue_req(ple_pkg::REQ_DELETE, 1, 'h00);    // head delete
        queue_req(ple_pkg::REQ_DELETE, 1, 'h00);    // last byte out
        queue_req(ple_pkg::REQ_DELETE, 16, 'h00);   // empty again

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold new beats until the directed part has fully drained.
        @(negedge i_clk);
        while (req_pending.size() != 0 || req_valid || rsp_expected.size() != 0)
            @(negedge i_clk);

        // Random part: fill runs to reach the full list, drain runs to reach
        // empty, mixed runs in between; a slice of noise everywhere.
        n = 0;
        while (n < RANDOM_REQS) begin
            mode = $urandom_range(0, 2);
            if (mode == 0) begin
                while (gen_len < LIST_CAP) begin
                    run_len = $urandom_range(0, 99);
                    if (run_len < 85)
                        queue_good_insert();
                    else if (run_len < 93 && gen_len > 0)
                        queue_good_delete();
                    else
                        queue_noise();
                    n++;
                end
                // Knock on the full list, including the tail position.
                repeat ($urandom_range(1, 3)) begin
                    queue_req(ple_pkg::REQ_INSERT, $urandom_range(1, LIST_CAP + 1),
                              pick_byte());
                    n++;
                end
            end else if (mode == 1) begin
                while (gen_len > 0) begin
                    run_len = $urandom_range(0, 99);
                    if (run_len < 85)
                        queue_good_delete();
                    else if (run_len < 93)
                        queue_good_insert();
                    else
                        queue_noise();
                    n++;
                end
                repeat ($urandom_range(1, 2)) begin
                    queue_req(ple_pkg::REQ_DELETE, $urandom_range(0, 17), pick_byte());
                    n++;
                end
            end else begin
                repeat ($urandom_range(10, 40)) begin
                    run_len = $urandom_range(0, 99);
                    if (run_len < 40)
                        queue_good_insert();
                    else if (run_len < 80 && gen_len > 0)
                        queue_good_delete();
                    else
                        queue_noise();
                    n++;
                end
            end
        end

        // Drain: every beat sent and every result back, then a short settle.
        while (req_pending.size() != 0 || req_valid || rsp_expected.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("%0d requests checked over %0d cycles: ok %0d, empty %0d, %s %0d, full %0d",
                 seen_count, cycle_count, status_hits[ple_pkg::ST_OK],
                 status_hits[ple_pkg::ST_EMPTY], "bad position",
                 status_hits[ple_pkg::ST_BADPOS], status_hits[ple_pkg::ST_FULL]);
        $display("deepest list reached %0d of %0d bytes; %0d mismatches",
                 peak_len, LIST_CAP, fail_count);
        if (fail_count == 0 && sent_count == seen_count)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine.sv
sim/tb_top.sv
